### design/ipr_pkg.sv
// Shared types, codes and helpers for the integer pixel readback converter.
package ipr_pkg;

    localparam int LANES = 4;

    typedef enum logic [2:0] {
        REG_SRC_COMPONENTS = 3'd0,
        REG_SRC_BYTES      = 3'd1,
        REG_SRC_KIND       = 3'd2,
        REG_OUT_COMPONENTS = 3'd3,
        REG_COMPONENT_MAP  = 3'd4,
        REG_OUT_KIND       = 3'd5,
        REG_OUT_BYTES      = 3'd6,
        REG_PACKED_LAYOUT  = 3'd7
    } t_reg_idx;

    localparam logic [1:0] SRC_SIGNED  = 2'd1;
    localparam logic [1:0] SRC_RGB10A2 = 2'd2;
    localparam logic [1:0] OUT_SIGNED  = 2'd1;
    localparam logic [1:0] OUT_PACKED  = 2'd2;

    typedef enum logic [1:0] {
        SZ_1 = 2'd0,
        SZ_2 = 2'd1,
        SZ_4 = 2'd2
    } t_size;

    // component value, two's complement, wide enough for u32 and s32
    typedef logic [32:0] t_comp;
    typedef t_comp [LANES-1:0] t_src_vec;

    typedef struct packed {
        logic [2:0] scount;
        logic       out_signed;
        t_size      size;
    } t_cvt_cfg;

    typedef struct packed {
        logic [2:0] map_code;
        logic [5:0] width;
        logic [4:0] shift;
        logic       is_alpha;
    } t_lane_cfg;

    typedef struct packed {
        logic [31:0] elem;
        logic [31:0] word_part;
    } t_lane_out;

    function automatic t_size size_of(input logic [2:0] code);
        t_size s;
        case (code)
            3'd1:    s = SZ_1;
            3'd2:    s = SZ_2;
            default: s = SZ_4;
        endcase
        return s;
    endfunction

endpackage

### design/ipr_channels.sv
// Channel interfaces: texel requests, result requests and register writes.
interface ipr_pixel_if;
    logic        valid;
    logic        ready;
    logic [63:0] pixel_low;
    logic [63:0] pixel_high;

    modport source (output valid, output pixel_low, output pixel_high, input ready);
    modport sink   (input valid, input pixel_low, input pixel_high, output ready);
endinterface

interface ipr_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic [4:0]  byte_count;

    modport source (output valid, output result_low, output result_high,
                    output byte_count, input ready);
    modport sink   (input valid, input result_low, input result_high,
                    input byte_count, output ready);
endinterface

interface ipr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [43:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/integer_pixel_readback_converter_top.sv
// Top level of the integer pixel readback converter.
//
//  channel    dir  handshake     payload
//  i_pixel    in   valid/ready   pixel_low[63:0], pixel_high[63:0]
//  o_result   out  valid/ready   result_low[63:0], result_high[63:0], byte_count[4:0]
//  i_cfg      in   valid/ready   index[2:0], data[43:0] (ready always high)
//
//  Two register stages: texel register, then four lanes and merge into the result
//  register. One texel per cycle sustained while the result side is not stalled.
//  Synchronous active-low reset clears both valid flags and loads register defaults.
//  A stalled result holds; the texel stage keeps accepting until it is full too.
module integer_pixel_readback_converter_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ipr_pixel_if.sink     i_pixel,
    ipr_result_if.source  o_result,
    ipr_cfg_if.sink       i_cfg
);

    logic [2:0]  r_src_components;
    logic [2:0]  r_src_bytes;
    logic [1:0]  r_src_kind;
    logic [2:0]  r_out_components;
    logic [11:0] r_map;
    logic [1:0]  r_out_kind;
    logic [2:0]  r_out_bytes;
    logic [43:0] r_layout;

    logic         r_s1_valid;
    logic [127:0] r_texel;
    logic         r_out_valid;
    logic [127:0] r_result;
    logic [4:0]   r_count;

    logic         w_advance;
    logic         w_in_ready;
    logic         w_accept;

    ipr_pkg::t_src_vec  w_src;
    ipr_pkg::t_cvt_cfg  w_cvt_cfg;
    ipr_pkg::t_lane_cfg w_lane_cfg [ipr_pkg::LANES];
    ipr_pkg::t_lane_out w_lane     [ipr_pkg::LANES];
    logic [127:0]       n_result;
    logic [4:0]         n_count;

    assign w_advance  = !r_out_valid || o_result.ready;
    assign w_in_ready = !r_s1_valid || w_advance;
    assign w_accept   = i_pixel.valid && w_in_ready;

    assign i_pixel.ready = w_in_ready;
    assign i_cfg.ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_components <= 3'd4;
            r_src_bytes      <= 3'd1;
            r_src_kind       <= 2'd0;
            r_out_components <= 3'd4;
            r_map            <= 12'd1672;
            r_out_kind       <= 2'd0;
            r_out_bytes      <= 3'd1;
            r_layout         <= 44'd0;
        end else if (i_cfg.valid) begin
            case (ipr_pkg::t_reg_idx'(i_cfg.index))
                ipr_pkg::REG_SRC_COMPONENTS: r_src_components <= i_cfg.data[2:0];
                ipr_pkg::REG_SRC_BYTES:      r_src_bytes      <= i_cfg.data[2:0];
                ipr_pkg::REG_SRC_KIND:       r_src_kind       <= i_cfg.data[1:0];
                ipr_pkg::REG_OUT_COMPONENTS: r_out_components <= i_cfg.data[2:0];
                ipr_pkg::REG_COMPONENT_MAP:  r_map            <= i_cfg.data[11:0];
                ipr_pkg::REG_OUT_KIND:       r_out_kind       <= i_cfg.data[1:0];
                ipr_pkg::REG_OUT_BYTES:      r_out_bytes      <= i_cfg.data[2:0];
                ipr_pkg::REG_PACKED_LAYOUT:  r_layout         <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_ready) r_s1_valid <= i_pixel.valid;
            if (w_advance) r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_texel <= {i_pixel.pixel_high, i_pixel.pixel_low};
        if (w_advance && r_s1_valid) begin
            r_result <= n_result;
            r_count  <= n_count;
        end
    end

    ipr_unpack u_unpack (
        .i_texel (r_texel),
        .i_size  (ipr_pkg::size_of(r_src_bytes)),
        .i_kind  (r_src_kind),
        .o_src   (w_src)
    );

    assign w_cvt_cfg.scount     = r_src_components;
    assign w_cvt_cfg.out_signed = (r_out_kind == ipr_pkg::OUT_SIGNED);
    assign w_cvt_cfg.size       = ipr_pkg::size_of(r_out_bytes);

    for (genvar g = 0; g < ipr_pkg::LANES; g++) begin : g_lane
        assign w_lane_cfg[g].map_code = r_map[3*g +: 3];
        assign w_lane_cfg[g].width    = r_layout[11*g +: 6];
        assign w_lane_cfg[g].shift    = r_layout[11*g+6 +: 5];
        assign w_lane_cfg[g].is_alpha = (g == ipr_pkg::LANES - 1);

        ipr_lane u_lane (
            .i_src      (w_src),
            .i_cfg      (w_cvt_cfg),
            .i_lane_cfg (w_lane_cfg[g]),
            .o_out      (w_lane[g])
        );
    end

    ipr_merge u_merge (
        .i_lane           (w_lane),
        .i_out_components (r_out_components),
        .i_out_kind       (r_out_kind),
        .i_size           (w_cvt_cfg.size),
        .o_bytes          (n_result),
        .o_count          (n_count)
    );

    assign o_result.valid       = r_out_valid;
    assign o_result.result_low  = r_result[63:0];
    assign o_result.result_high = r_result[127:64];
    assign o_result.byte_count  = r_count;

endmodule

### design/ipr_unpack.sv
// Splits a raw source texel into four component values.
module ipr_unpack (
    input  logic [127:0]     i_texel,
    input  ipr_pkg::t_size   i_size,
    input  logic [1:0]       i_kind,
    output ipr_pkg::t_src_vec o_src
);

    logic        w_sext;
    logic [31:0] w_word;

    assign w_sext = (i_kind == ipr_pkg::SRC_SIGNED);
    assign w_word = i_texel[31:0];

    always_comb begin
        o_src = '0;
        for (int c = 0; c < ipr_pkg::LANES; c++) begin
            if (i_kind == ipr_pkg::SRC_RGB10A2) begin
                if (c == ipr_pkg::LANES - 1) begin
                    o_src[c] = {31'd0, w_word[31:30]};
                end else begin
                    o_src[c] = {23'd0, w_word[10*c +: 10]};
                end
            end else begin
                case (i_size)
                    ipr_pkg::SZ_1: begin
                        o_src[c] = {{25{w_sext & i_texel[8*c+7]}}, i_texel[8*c +: 8]};
                    end
                    ipr_pkg::SZ_2: begin
                        o_src[c] = {{17{w_sext & i_texel[16*c+15]}}, i_texel[16*c +: 16]};
                    end
                    default: begin
                        o_src[c] = {w_sext & i_texel[32*c+31], i_texel[32*c +: 32]};
                    end
                endcase
            end
        end
    end

endmodule

### design/ipr_lane.sv
// One output component: source select, per-component clamp and packed-field clamp.
module ipr_lane (
    input  ipr_pkg::t_src_vec  i_src,
    input  ipr_pkg::t_cvt_cfg  i_cfg,
    input  ipr_pkg::t_lane_cfg i_lane_cfg,
    output ipr_pkg::t_lane_out o_out
);

    logic [1:0]         w_sel;
    logic               w_hit;
    ipr_pkg::t_comp     w_val;
    logic signed [32:0] w_sval;
    logic signed [32:0] w_hi;
    logic signed [32:0] w_lo;
    logic signed [32:0] w_clamped;
    logic [31:0]        w_nonneg;
    logic [31:0]        w_max;
    logic               w_over;
    logic [31:0]        w_field;

    assign w_sel  = i_lane_cfg.map_code[1:0];
    assign w_hit  = !i_lane_cfg.map_code[2] && ({1'b0, w_sel} < i_cfg.scount);
    assign w_val  = w_hit ? i_src[w_sel] : {32'd0, i_lane_cfg.is_alpha};
    assign w_sval = $signed(w_val);

    always_comb begin
        case (i_cfg.size)
            ipr_pkg::SZ_1: begin
                w_hi = i_cfg.out_signed ? 33'sd127 : 33'sd255;
                w_lo = i_cfg.out_signed ? -33'sd128 : 33'sd0;
            end
            ipr_pkg::SZ_2: begin
                w_hi = i_cfg.out_signed ? 33'sd32767 : 33'sd65535;
                w_lo = i_cfg.out_signed ? -33'sd32768 : 33'sd0;
            end
            default: begin
                w_hi = i_cfg.out_signed ? 33'sh0_7FFF_FFFF : 33'sh0_FFFF_FFFF;
                w_lo = i_cfg.out_signed ? -33'sh0_8000_0000 : 33'sd0;
            end
        endcase
    end

    assign w_clamped = (w_sval > w_hi) ? w_hi : ((w_sval < w_lo) ? w_lo : w_sval);

    // packed word field: negative to zero, optional upper clamp, then shift
    assign w_nonneg = w_val[32] ? 32'd0 : w_val[31:0];
    assign w_max    = (32'd1 << i_lane_cfg.width[4:0]) - 32'd1;
    assign w_over   = !i_lane_cfg.width[5] && ((w_nonneg >> i_lane_cfg.width[4:0]) != 32'd0);
    assign w_field  = w_over ? w_max : w_nonneg;

    assign o_out.elem      = w_clamped[31:0];
    assign o_out.word_part = w_field << i_lane_cfg.shift;

endmodule

### design/ipr_merge.sv
// Combines lane results into the output byte image and its byte count.
module ipr_merge (
    input  ipr_pkg::t_lane_out i_lane [ipr_pkg::LANES],
    input  logic [2:0]         i_out_components,
    input  logic [1:0]         i_out_kind,
    input  ipr_pkg::t_size     i_size,
    output logic [127:0]       o_bytes,
    output logic [4:0]         o_count
);

    logic [2:0]  w_ocount;
    logic [31:0] w_word;

    assign w_ocount = (i_out_components > 3'd4) ? 3'd4 : i_out_components;

    always_comb begin
        w_word = '0;
        for (int c = 0; c < ipr_pkg::LANES; c++) begin
            if (3'(c) < w_ocount) begin
                w_word = w_word | i_lane[c].word_part;
            end
        end
    end

    always_comb begin
        o_bytes = '0;
        if (i_out_kind == ipr_pkg::OUT_PACKED) begin
            case (i_size)
                ipr_pkg::SZ_1: begin
                    o_bytes = {120'd0, w_word[7:0]};
                    o_count = 5'd1;
                end
                ipr_pkg::SZ_2: begin
                    o_bytes = {112'd0, w_word[15:0]};
                    o_count = 5'd2;
                end
                default: begin
                    o_bytes = {96'd0, w_word};
                    o_count = 5'd4;
                end
            endcase
        end else begin
            case (i_size)
                ipr_pkg::SZ_1: begin
                    for (int c = 0; c < ipr_pkg::LANES; c++) begin
                        if (3'(c) < w_ocount) o_bytes[8*c +: 8] = i_lane[c].elem[7:0];
                    end
                    o_count = {2'd0, w_ocount};
                end
                ipr_pkg::SZ_2: begin
                    for (int c = 0; c < ipr_pkg::LANES; c++) begin
                        if (3'(c) < w_ocount) o_bytes[16*c +: 16] = i_lane[c].elem[15:0];
                    end
                    o_count = {1'b0, w_ocount, 1'b0};
                end
                default: begin
                    for (int c = 0; c < ipr_pkg::LANES; c++) begin
                        if (3'(c) < w_ocount) o_bytes[32*c +: 32] = i_lane[c].elem;
                    end
                    o_count = {w_ocount, 2'd0};
                end
            endcase
        end
    end

endmodule

### design/ipr_checker.sv
// Port-level checks for the converter top level, attached by bind.
module ipr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_result_low,
    input logic [63:0] i_result_high,
    input logic [4:0]  i_byte_count
);

    a_backpressure_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready)
    ) else $error("input stalled while result side can move");

    a_request_reaches_output: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) |=> ##1 i_out_valid
    ) else $error("accepted request did not reach the result register");

    a_count_bound: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_byte_count <= 5'd16)
    ) else $error("byte count above sixteen");

    a_unused_bytes_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_byte_count <= 5'd8) |-> (i_result_high == 64'd0)
    ) else $error("bytes beyond the count are not zero");

    a_stall_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_result_low) && $stable(i_result_high)
             && $stable(i_byte_count))
    ) else $error("stalled result changed");

endmodule

bind integer_pixel_readback_converter_top ipr_checker u_ipr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_pixel.valid),
    .i_in_ready    (i_pixel.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_result_low  (o_result.result_low),
    .i_result_high (o_result.result_high),
    .i_byte_count  (o_result.byte_count)
);
